>>> rtl/mfv_pkg.sv
package mfv_pkg;

  localparam logic [7:0] START_LONG  = 8'h68;
  localparam logic [7:0] START_SHORT = 8'h10;
  localparam logic [7:0] STOP_BYTE   = 8'h16;
  localparam logic [7:0] ACK_BYTE    = 8'hE5;
  localparam logic [7:0] CI_RESPONSE = 8'h72;

  localparam int unsigned POS_W     = 9;
  localparam int unsigned HDR_SLOTS = 13;
  localparam int unsigned SLOT_W    = 4;

  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_SHORT     = 3'd1;
  localparam logic [2:0] ST_BAD_START = 3'd2;
  localparam logic [2:0] ST_BAD_LEN   = 3'd3;
  localparam logic [2:0] ST_BAD_STOP  = 3'd4;
  localparam logic [2:0] ST_BAD_SUM   = 3'd5;

  localparam logic [1:0] KIND_UNKNOWN = 2'd0;
  localparam logic [1:0] KIND_ACK     = 2'd1;
  localparam logic [1:0] KIND_SHORT   = 2'd2;
  localparam logic [1:0] KIND_LONG    = 2'd3;

  typedef enum logic [2:0] {
    OP_IGNORE,
    OP_SUM,
    OP_CHK_LEN,
    OP_CHK_START,
    OP_CHK_SUM,
    OP_CHK_STOP
  } op_e;

  typedef struct packed {
    op_e               op;
    logic [7:0]        data;
    logic              store_en;
    logic [SLOT_W-1:0] slot;
    logic              last;
    logic [1:0]        kind;
    logic              too_short;
    logic              trunc;
    logic [7:0]        len;
  } item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [1:0]  kind;
    logic [7:0]  ctrl;
    logic [7:0]  addr;
    logic [7:0]  ci;
    logic [7:0]  len;
    logic [31:0] sec_addr;
    logic [15:0] manu;
    logic [7:0]  version;
    logic [7:0]  med_code;
    logic [7:0]  access;
    logic [7:0]  mstatus;
  } verdict_t;

endpackage

>>> rtl/mfv_front.sv
module mfv_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  input  logic [7:0]    byte_i,
  input  logic          last_i,
  input  logic          full_i,
  output logic          ready_o,
  output logic          push_o,
  output mfv_pkg::item_t item_o
);

  logic [mfv_pkg::POS_W-1:0] pos_q, pos_d;
  logic [7:0]                first_q, first_d;
  logic [7:0]                len_q, len_d;
  logic                      done_q, done_d;
  logic [7:0]                cur_first;
  logic [9:0]                pos_x, lim3, lim4, lim5;
  logic                      accept;

  assign ready_o = !full_i;
  assign accept  = valid_i && !full_i;
  assign push_o  = accept;

  assign cur_first = (pos_q == '0) ? byte_i : first_q;
  assign pos_x     = {1'b0, pos_q};
  assign lim3      = {2'b00, len_q} + 10'd3;
  assign lim4      = {2'b00, len_q} + 10'd4;
  assign lim5      = {2'b00, len_q} + 10'd5;

  always_comb begin
    pos_d   = pos_q;
    first_d = first_q;
    len_d   = len_q;
    done_d  = done_q;
    item_o          = '0;
    item_o.op       = mfv_pkg::OP_IGNORE;
    item_o.data     = byte_i;
    item_o.last     = last_i;
    if (!done_q) begin
      if (pos_q == '0) begin
        first_d = byte_i;
        if (byte_i != mfv_pkg::START_SHORT && byte_i != mfv_pkg::START_LONG) begin
          done_d = 1'b1;
        end
      end else if (first_q == mfv_pkg::START_SHORT) begin
        if (pos_q == 9'd1 || pos_q == 9'd2) begin
          item_o.op       = mfv_pkg::OP_SUM;
          item_o.store_en = 1'b1;
          item_o.slot     = pos_q[mfv_pkg::SLOT_W-1:0] - 4'd1;
        end else if (pos_q == 9'd3) begin
          item_o.op = mfv_pkg::OP_CHK_SUM;
        end else if (pos_q == 9'd4) begin
          item_o.op = mfv_pkg::OP_CHK_STOP;
          done_d    = 1'b1;
        end
      end else begin
        if (pos_q == 9'd1) begin
          len_d = byte_i;
        end else if (pos_q == 9'd2) begin
          item_o.op = mfv_pkg::OP_CHK_LEN;
        end else if (pos_q == 9'd3) begin
          item_o.op = mfv_pkg::OP_CHK_START;
        end else if (pos_x <= lim3) begin
          item_o.op = mfv_pkg::OP_SUM;
          if (pos_q <= 9'd16) begin
            item_o.store_en = 1'b1;
            item_o.slot     = pos_q[mfv_pkg::SLOT_W-1:0] - 4'd4;
          end
        end else if (pos_x == lim4) begin
          item_o.op = mfv_pkg::OP_CHK_SUM;
        end else if (pos_x == lim5) begin
          item_o.op = mfv_pkg::OP_CHK_STOP;
          done_d    = 1'b1;
        end
      end
    end
    if (pos_q != '1) begin
      pos_d = pos_q + 1'b1;
    end

    item_o.len = len_d;
    unique case (cur_first)
      mfv_pkg::ACK_BYTE:    item_o.kind = mfv_pkg::KIND_ACK;
      mfv_pkg::START_SHORT: item_o.kind = mfv_pkg::KIND_SHORT;
      mfv_pkg::START_LONG:  item_o.kind = mfv_pkg::KIND_LONG;
      default:              item_o.kind = mfv_pkg::KIND_UNKNOWN;
    endcase
    item_o.too_short = (cur_first == mfv_pkg::START_SHORT) ? (pos_q < 9'd4) : (pos_q < 9'd8);
    item_o.trunc     = ({2'b00, len_d} + 10'd6) > (pos_x + 10'd1);

    if (last_i) begin
      pos_d   = '0;
      first_d = '0;
      len_d   = '0;
      done_d  = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      first_q <= '0;
      len_q   <= '0;
      done_q  <= 1'b0;
    end else if (accept) begin
      pos_q   <= pos_d;
      first_q <= first_d;
      len_q   <= len_d;
      done_q  <= done_d;
    end
  end

endmodule

>>> rtl/mfv_fifo.sv
module mfv_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  mfv_pkg::item_t item_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           valid_o,
  output mfv_pkg::item_t item_o
);

  mfv_pkg::item_t                 mem_q [mfv_pkg::QDEPTH];
  logic [mfv_pkg::QPTR_W-1:0]     wr_ptr_q, rd_ptr_q;
  logic [mfv_pkg::QCNT_W-1:0]     cnt_q;
  logic                           do_pop;

  assign full_o  = (cnt_q == mfv_pkg::QCNT_W'(mfv_pkg::QDEPTH));
  assign valid_o = (cnt_q != '0);
  assign item_o  = mem_q[rd_ptr_q];
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == mfv_pkg::QPTR_W'(mfv_pkg::QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == mfv_pkg::QPTR_W'(mfv_pkg::QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= mfv_pkg::QCNT_W'(mfv_pkg::QDEPTH))
    else $error("queue count beyond depth");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> !push_i)
    else $error("push into full queue");

endmodule

>>> rtl/mfv_back.sv
module mfv_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              q_valid_i,
  input  mfv_pkg::item_t    q_item_i,
  output logic              q_pop_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output mfv_pkg::verdict_t out_o
);

  logic [7:0]        sum_q, sum_d;
  logic [2:0]        fe_q, fe_d, err;
  logic [7:0]        slot_q [mfv_pkg::HDR_SLOTS];
  logic [7:0]        slot_nx [mfv_pkg::HDR_SLOTS];
  logic              out_valid_q;
  mfv_pkg::verdict_t out_q, verdict;
  logic              pop;
  logic              fields, hdr;

  assign pop     = q_valid_i && (!q_item_i.last || !out_valid_q || out_ready_i);
  assign q_pop_o = pop;

  always_comb begin
    err   = mfv_pkg::ST_OK;
    sum_d = sum_q;
    case (q_item_i.op)
      mfv_pkg::OP_SUM:       sum_d = sum_q + q_item_i.data;
      mfv_pkg::OP_CHK_LEN:   if (q_item_i.data != q_item_i.len) err = mfv_pkg::ST_BAD_LEN;
      mfv_pkg::OP_CHK_START: if (q_item_i.data != mfv_pkg::START_LONG) err = mfv_pkg::ST_BAD_START;
      mfv_pkg::OP_CHK_SUM:   if (q_item_i.data != sum_q) err = mfv_pkg::ST_BAD_SUM;
      mfv_pkg::OP_CHK_STOP:  if (q_item_i.data != mfv_pkg::STOP_BYTE) err = mfv_pkg::ST_BAD_STOP;
      default:               err = mfv_pkg::ST_OK;
    endcase
    fe_d = fe_q;
    if (err != mfv_pkg::ST_OK && (fe_q == mfv_pkg::ST_OK || err < fe_q)) begin
      fe_d = err;
    end
    for (int k = 0; k < mfv_pkg::HDR_SLOTS; k++) begin
      slot_nx[k] = (q_item_i.store_en && q_item_i.slot == mfv_pkg::SLOT_W'(k))
                   ? q_item_i.data : slot_q[k];
    end
  end

  always_comb begin
    verdict      = '0;
    verdict.kind = q_item_i.kind;
    unique case (q_item_i.kind)
      mfv_pkg::KIND_ACK:   verdict.status = mfv_pkg::ST_OK;
      mfv_pkg::KIND_SHORT: verdict.status = q_item_i.too_short ? mfv_pkg::ST_SHORT : fe_d;
      mfv_pkg::KIND_LONG: begin
        if (q_item_i.too_short) begin
          verdict.status = mfv_pkg::ST_SHORT;
        end else if (fe_d == mfv_pkg::ST_BAD_START || fe_d == mfv_pkg::ST_BAD_LEN) begin
          verdict.status = fe_d;
        end else if (q_item_i.trunc) begin
          verdict.status = mfv_pkg::ST_SHORT;
        end else begin
          verdict.status = fe_d;
        end
      end
      default:             verdict.status = mfv_pkg::ST_BAD_START;
    endcase
    fields = (verdict.status == mfv_pkg::ST_OK) &&
             (q_item_i.kind == mfv_pkg::KIND_SHORT || q_item_i.kind == mfv_pkg::KIND_LONG);
    hdr    = fields && (q_item_i.kind == mfv_pkg::KIND_LONG) &&
             (slot_nx[2] == mfv_pkg::CI_RESPONSE);
    if (fields) begin
      verdict.ctrl = slot_nx[0];
      verdict.addr = slot_nx[1];
      if (q_item_i.kind == mfv_pkg::KIND_LONG) begin
        verdict.ci  = slot_nx[2];
        verdict.len = q_item_i.len;
      end
    end
    if (hdr) begin
      verdict.sec_addr = {slot_nx[6], slot_nx[5], slot_nx[4], slot_nx[3]};
      verdict.manu     = {slot_nx[8], slot_nx[7]};
      verdict.version  = slot_nx[9];
      verdict.med_code = slot_nx[10];
      verdict.access   = slot_nx[11];
      verdict.mstatus  = slot_nx[12];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
      fe_q  <= mfv_pkg::ST_OK;
      for (int k = 0; k < mfv_pkg::HDR_SLOTS; k++) begin
        slot_q[k] <= '0;
      end
    end else if (pop) begin
      if (q_item_i.last) begin
        sum_q <= '0;
        fe_q  <= mfv_pkg::ST_OK;
        for (int k = 0; k < mfv_pkg::HDR_SLOTS; k++) begin
          slot_q[k] <= '0;
        end
      end else begin
        sum_q <= sum_d;
        fe_q  <= fe_d;
        for (int k = 0; k < mfv_pkg::HDR_SLOTS; k++) begin
          slot_q[k] <= slot_nx[k];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (pop && q_item_i.last) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop && q_item_i.last) begin
      out_q <= verdict;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> out_q.status <= mfv_pkg::ST_BAD_SUM)
    else $error("status code out of range");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.status != mfv_pkg::ST_OK |->
      out_q.ctrl == 8'd0 && out_q.addr == 8'd0 && out_q.sec_addr == 32'd0)
    else $error("fields set on an error verdict");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.kind == mfv_pkg::KIND_UNKNOWN |-> out_q.status == mfv_pkg::ST_BAD_START)
    else $error("unknown frame not flagged as bad start");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.kind == mfv_pkg::KIND_ACK |-> out_q.status == mfv_pkg::ST_OK)
    else $error("ack verdict not ok");

endmodule

>>> rtl/mbus_frame_validator.sv
// Checks one received M-Bus buffer (ack byte, short frame or long frame) fed one byte per
// transaction, with tlast on the final byte of the buffer, and returns one verdict transaction
// per buffer carrying status, frame kind, C, A, CI, L and, for a good long frame with CI 0x72,
// the response header. Bytes are taken at one per clock while the queue is not full; the
// verdict is output once its last byte has passed the two-entry queue between the classifying
// front end and the checking back end and then the output register. While a verdict waits on
// m_axis_tready, bytes keep flowing until the final byte of the next buffer reaches the head
// of the queue and one more transaction has queued behind it.
module mbus_frame_validator (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [7:0]   s_axis_tdata,   // rx_byte
  input  logic         s_axis_tlast,   // end_of_buffer
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // status, control_field, address_field, control_info, length_field, secondary_address,
  // manufacturer_code, device_version, medium_code, access_number, meter_status, zero pad
  output logic [119:0] m_axis_tdata,
  output logic [1:0]   m_axis_tuser    // frame_kind
);

  logic              push, full, q_valid, q_pop;
  mfv_pkg::item_t    f_item, q_item;
  mfv_pkg::verdict_t res;

  mfv_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid),
    .byte_i  (s_axis_tdata),
    .last_i  (s_axis_tlast),
    .full_i  (full),
    .ready_o (s_axis_tready),
    .push_o  (push),
    .item_o  (f_item)
  );

  mfv_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (f_item),
    .full_o  (full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .item_o  (q_item)
  );

  mfv_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_item_i    (q_item),
    .q_pop_o     (q_pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_o       (res)
  );

  assign m_axis_tuser = res.kind;
  assign m_axis_tdata = {5'd0, res.mstatus, res.access, res.med_code, res.version, res.manu,
                         res.sec_addr, res.len, res.ci, res.addr, res.ctrl, res.status};

endmodule

>>> verif/mbus_frame_validator_tb.sv
module mbus_frame_validator_tb;

  localparam int unsigned RAND_BYTES  = 620;
  localparam int unsigned QUIET_TAIL  = 300;
  localparam int unsigned RX_HOLD     = 150;
  localparam int unsigned STALL_LIMIT = 2000;

  class verdict_scoreboard;
    mfv_pkg::verdict_t expected_q[$];
    int unsigned errors;
    logic [8:0]  pos;
    logic [7:0]  lead;
    logic [7:0]  l_byte;
    logic [7:0]  sum;
    logic [2:0]  err_code;
    bit          frame_end;
    logic [7:0]  hdr[16];

    function new();
      errors = 0;
      clear();
    endfunction

    function void clear();
      pos       = '0;
      lead      = '0;
      l_byte    = '0;
      sum       = '0;
      err_code  = mfv_pkg::ST_OK;
      frame_end = 1'b0;
      foreach (hdr[i]) hdr[i] = '0;
    endfunction

    function void flag(logic [2:0] code);
      if (err_code == mfv_pkg::ST_OK || code < err_code) err_code = code;
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    // predicts the verdict of the current buffer from one accepted byte
    function void note_byte(logic [7:0] b, logic eob);
      int unsigned       p;
      int unsigned       ll;
      int unsigned       buf_len;
      mfv_pkg::verdict_t v;
      p  = pos;
      ll = l_byte + 6;
      if (!frame_end) begin
        if (p == 0) begin
          lead = b;
          if (b != mfv_pkg::START_SHORT && b != mfv_pkg::START_LONG) frame_end = 1'b1;
        end else if (lead == mfv_pkg::START_SHORT) begin
          if (p == 1 || p == 2) begin
            hdr[p-1] = b;
            sum = sum + b;
          end else if (p == 3) begin
            if (b != sum) flag(mfv_pkg::ST_BAD_SUM);
          end else if (p == 4) begin
            if (b != mfv_pkg::STOP_BYTE) flag(mfv_pkg::ST_BAD_STOP);
            frame_end = 1'b1;
          end
        end else begin
          if (p == 1) begin
            l_byte = b;
          end else if (p == 2) begin
            if (b != l_byte) flag(mfv_pkg::ST_BAD_LEN);
          end else if (p == 3) begin
            if (b != mfv_pkg::START_LONG) flag(mfv_pkg::ST_BAD_START);
          end else if (p <= ll - 3) begin
            sum = sum + b;
            if (p <= 16) hdr[p-4] = b;
          end else if (p == ll - 2) begin
            if (b != sum) flag(mfv_pkg::ST_BAD_SUM);
          end else if (p == ll - 1) begin
            if (b != mfv_pkg::STOP_BYTE) flag(mfv_pkg::ST_BAD_STOP);
            frame_end = 1'b1;
          end
        end
      end
      if (pos < 9'd511) pos = pos + 9'd1;
      if (!eob) return;

      buf_len = p + 1;
      ll = l_byte + 6;
      v = '0;
      if (lead == mfv_pkg::ACK_BYTE) begin
        v.kind   = mfv_pkg::KIND_ACK;
        v.status = mfv_pkg::ST_OK;
      end else if (lead == mfv_pkg::START_SHORT) begin
        v.kind   = mfv_pkg::KIND_SHORT;
        v.status = (buf_len < 5) ? mfv_pkg::ST_SHORT : err_code;
      end else if (lead == mfv_pkg::START_LONG) begin
        v.kind = mfv_pkg::KIND_LONG;
        if (buf_len < 9) v.status = mfv_pkg::ST_SHORT;
        else if (err_code == mfv_pkg::ST_BAD_START || err_code == mfv_pkg::ST_BAD_LEN)
          v.status = err_code;
        else if (ll > buf_len) v.status = mfv_pkg::ST_SHORT;
        else v.status = err_code;
      end else begin
        v.kind   = mfv_pkg::KIND_UNKNOWN;
        v.status = mfv_pkg::ST_BAD_START;
      end
      if (v.status == mfv_pkg::ST_OK &&
          (v.kind == mfv_pkg::KIND_SHORT || v.kind == mfv_pkg::KIND_LONG)) begin
        v.ctrl = hdr[0];
        v.addr = hdr[1];
        if (v.kind == mfv_pkg::KIND_LONG) begin
          v.ci  = hdr[2];
          v.len = l_byte;
          if (hdr[2] == mfv_pkg::CI_RESPONSE) begin
            v.sec_addr = {hdr[6], hdr[5], hdr[4], hdr[3]};
            v.manu     = {hdr[8], hdr[7]};
            v.version  = hdr[9];
            v.med_code = hdr[10];
            v.access   = hdr[11];
            v.mstatus  = hdr[12];
          end
        end
      end
      expected_q.push_back(v);
      clear();
    endfunction

    function void compare(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_verdict(logic [119:0] d, logic [1:0] kind);
      mfv_pkg::verdict_t w;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected verdict, expected none, actual %0h kind %0d",
                 $time, d, kind);
        errors++;
        return;
      end
      w = expected_q.pop_front();
      compare("status", w.status, d[2:0]);
      compare("frame_kind", w.kind, kind);
      compare("control_field", w.ctrl, d[10:3]);
      compare("address_field", w.addr, d[18:11]);
      compare("control_info", w.ci, d[26:19]);
      compare("length_field", w.len, d[34:27]);
      compare("secondary_address", w.sec_addr, d[66:35]);
      compare("manufacturer_code", w.manu, d[82:67]);
      compare("device_version", w.version, d[90:83]);
      compare("medium_code", w.med_code, d[98:91]);
      compare("access_number", w.access, d[106:99]);
      compare("meter_status", w.mstatus, d[114:107]);
    endfunction
  endclass

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [7:0]   s_axis_tdata = '0;
  logic         s_axis_tlast = 1'b0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [119:0] m_axis_tdata;
  logic [1:0]   m_axis_tuser;

  verdict_scoreboard sb = new();
  logic [7:0]  buf_q[$];
  bit          idle_en = 1'b1;
  bit          hold_rx = 1'b0;
  int unsigned rand_bytes = 0;

  mbus_frame_validator uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_verdict(m_axis_tdata, m_axis_tuser);
  end

  // receiver side
  initial begin
    forever begin
      if (hold_rx) begin
        m_axis_tready <= 1'b0;
        repeat (RX_HOLD) @(posedge clk_i);
        hold_rx = 1'b0;
      end else if (idle_en && $urandom_range(0, 4) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk_i);
    end
  end

  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) quiet = 0;
      else quiet++;
    end
    $display("FAIL mbus_frame_validator");
    $finish;
  end

  task automatic send_byte(logic [7:0] b, logic last);
    if (idle_en && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_byte(b, last);
  endtask

  task automatic send_buffer();
    foreach (buf_q[i]) send_byte(buf_q[i], i == buf_q.size() - 1);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  function automatic void make_short(logic [7:0] c, logic [7:0] a);
    buf_q = {mfv_pkg::START_SHORT, c, a, 8'(c + a), mfv_pkg::STOP_BYTE};
  endfunction

  // body holds C, A, CI and data, cut to l_len bytes
  function automatic void make_long(int unsigned l_len, logic [7:0] ci_val);
    logic [7:0] cs;
    logic [7:0] b;
    cs = '0;
    buf_q = {mfv_pkg::START_LONG, 8'(l_len), 8'(l_len), mfv_pkg::START_LONG};
    for (int i = 0; i < l_len; i++) begin
      b = (i == 2) ? ci_val : 8'($urandom);
      buf_q.push_back(b);
      cs = cs + b;
    end
    buf_q.push_back(cs);
    buf_q.push_back(mfv_pkg::STOP_BYTE);
  endfunction

  function automatic void trim_to(int unsigned n);
    while (buf_q.size() > n) void'(buf_q.pop_back());
  endfunction

  function automatic void append_noise(int unsigned n);
    repeat (n) buf_q.push_back(8'($urandom));
  endfunction

  function automatic void random_buffer();
    int unsigned pick;
    int unsigned l_len;
    int unsigned idx;
    pick = $urandom_range(0, 99);
    if (pick < 55) begin
      pick = $urandom_range(0, 99);
      if (pick < 80) l_len = $urandom_range(3, 20);
      else if (pick < 95) l_len = $urandom_range(0, 60);
      else l_len = $urandom_range(200, 255);
      make_long(l_len, $urandom_range(0, 1) ? mfv_pkg::CI_RESPONSE : 8'($urandom));
    end else if (pick < 80) begin
      make_short(8'($urandom), 8'($urandom));
    end else if (pick < 88) begin
      buf_q = {mfv_pkg::ACK_BYTE};
      append_noise($urandom_range(0, 3));
    end else begin
      buf_q = {};
      append_noise($urandom_range(1, 12));
    end
    case ($urandom_range(0, 9))
      0: begin
        idx = $urandom_range(0, buf_q.size() - 1);
        buf_q[idx] = buf_q[idx] ^ 8'($urandom_range(1, 255));
      end
      1: begin
        if (buf_q.size() > 1) trim_to($urandom_range(1, buf_q.size() - 1));
      end
      2: append_noise($urandom_range(1, 4));
      default: ;
    endcase
  endfunction

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // ack alone and with trailing bytes
    buf_q = {mfv_pkg::ACK_BYTE};
    send_buffer();
    buf_q = {mfv_pkg::ACK_BYTE, 8'h00, 8'hFF};
    send_buffer();
    // short frames: good, wrapping sum, truncated, bad sum, bad stop, both, trailing
    make_short(8'h53, 8'hFE);
    send_buffer();
    make_short(8'hFF, 8'hFF);
    send_buffer();
    make_short(8'h40, 8'h01);
    trim_to(3);
    send_buffer();
    make_short(8'h7B, 8'h05);
    buf_q[3] = buf_q[3] ^ 8'h01;
    send_buffer();
    make_short(8'h08, 8'h00);
    buf_q[4] = 8'h00;
    send_buffer();
    make_short(8'h08, 8'h00);
    buf_q[3] = buf_q[3] ^ 8'h80;
    buf_q[4] = 8'hFF;
    send_buffer();
    make_short(8'h5B, 8'h21);
    append_noise(3);
    send_buffer();
    // long frames: full response header, minimal, too short
    make_long(15, mfv_pkg::CI_RESPONSE);
    send_buffer();
    make_long(3, 8'h51);
    send_buffer();
    make_long(0, 8'h00);
    send_buffer();
    make_long(2, 8'h00);
    send_buffer();
    // response header cut short by L
    make_long(8, mfv_pkg::CI_RESPONSE);
    send_buffer();
    // length mismatch, bad second start, truncated, bad stop, bad sum
    make_long(6, 8'h72);
    buf_q[2] = buf_q[2] ^ 8'h01;
    send_buffer();
    make_long(6, 8'h72);
    buf_q[3] = mfv_pkg::START_SHORT;
    send_buffer();
    make_long(20, mfv_pkg::CI_RESPONSE);
    trim_to(15);
    send_buffer();
    make_long(10, 8'h78);
    buf_q[buf_q.size() - 1] = 8'h00;
    send_buffer();
    make_long(10, 8'h78);
    buf_q[buf_q.size() - 2] = buf_q[buf_q.size() - 2] ^ 8'h80;
    send_buffer();
    // length mismatch wins over bad sum
    make_long(5, 8'h72);
    buf_q[2] = buf_q[2] ^ 8'h01;
    buf_q[buf_q.size() - 2] = buf_q[buf_q.size() - 2] ^ 8'h01;
    send_buffer();
    make_long(10, 8'h7A);
    append_noise(3);
    send_buffer();
    // L of 255 needs a 9 bit compare
    make_long(255, mfv_pkg::CI_RESPONSE);
    trim_to(12);
    send_buffer();
    make_long(255, mfv_pkg::CI_RESPONSE);
    send_buffer();
    // position counter runs into its ceiling
    make_long(255, mfv_pkg::CI_RESPONSE);
    append_noise(300);
    send_buffer();
    // unknown first byte and lone start bytes
    buf_q = {8'h00};
    send_buffer();
    buf_q = {8'hFF, 8'h10, 8'h68};
    send_buffer();
    buf_q = {mfv_pkg::START_LONG};
    send_buffer();
    buf_q = {mfv_pkg::START_SHORT};
    send_buffer();

    drain();

    // long receiver stall while short frames keep coming
    hold_rx = 1'b1;
    repeat (6) begin
      make_short(8'($urandom), 8'($urandom));
      send_buffer();
    end

    while (rand_bytes < RAND_BYTES) begin
      if (rand_bytes + QUIET_TAIL >= RAND_BYTES) idle_en = 1'b0;
      random_buffer();
      send_buffer();
      rand_bytes += buf_q.size();
    end
    // finish with one more buffer, a lone ack byte
    buf_q = {mfv_pkg::ACK_BYTE};
    send_buffer();

    drain();
    repeat (10) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("PASS mbus_frame_validator");
    end else begin
      $display("FAIL mbus_frame_validator");
    end
    $finish;
  end

endmodule
